FILE: hdl/lpht_pkg.sv
// Shared types, codes and command/status bundles for the linear probe hash table.
package lpht_pkg;

    localparam int DEF_SLOTS      = 1024;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_VALUE_BITS = 32;

    localparam int LOAD_NUM = 8;
    localparam int LOAD_DEN = 10;

    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SLOTS       = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_EMPTY_KEY   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_EMPTY_VALUE = 2'd2;

    localparam int OP_BITS = 2;
    localparam logic [OP_BITS-1:0] OP_INSERT  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_REPLACE = 2'd2;

    localparam int STATUS_BITS = 3;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_HIT       = 3'd0,
        ST_MISS      = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_EXISTED   = 3'd3,
        ST_FULL      = 3'd4,
        ST_EMPTY_KEY = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        VS_EMPTY = 2'd0,
        VS_READ  = 2'd1,
        VS_NEW   = 2'd2
    } vsel_t;

    typedef struct packed {
        logic    clr_step;
        logic    load;
        logic    div_step;
        logic    probe_start;
        logic    adv;
        logic    wr;
        logic    cnt_inc;
        logic    res_load;
        status_t res_status;
        vsel_t   res_vsel;
        logic    res_slot_zero;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic div_done;
        logic ek_refuse;
        logic is_lookup;
        logic is_replace;
        logic hit;
        logic free;
        logic exhausted;
        logic full;
        logic out_free;
    } stat_t;

endpackage

FILE: hdl/lpht_ctrl.sv
// Sequencer: clearing pass, divide, probe walk and result hand-off.
module lpht_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  lpht_pkg::stat_t  stat,
    output lpht_pkg::cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_DIV, S_READ, S_CHECK, S_FIN
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        cmd.res_status = lpht_pkg::ST_MISS;
        cmd.res_vsel   = lpht_pkg::VS_EMPTY;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (stat.clr_done) begin
                    state_next = S_IDLE;
                end else begin
                    cmd.clr_step = 1'b1;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (stat.ek_refuse) begin
                    cmd.res_load      = 1'b1;
                    cmd.res_status    = lpht_pkg::ST_EMPTY_KEY;
                    cmd.res_slot_zero = 1'b1;
                    state_next        = S_FIN;
                end else if (stat.div_done) begin
                    cmd.probe_start = 1'b1;
                    state_next      = S_READ;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_READ: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (stat.hit) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_FIN;
                    if (stat.is_lookup) begin
                        cmd.res_status = lpht_pkg::ST_HIT;
                        cmd.res_vsel   = lpht_pkg::VS_READ;
                    end else if (stat.is_replace) begin
                        cmd.wr         = 1'b1;
                        cmd.res_status = lpht_pkg::ST_EXISTED;
                        cmd.res_vsel   = lpht_pkg::VS_NEW;
                    end else begin
                        cmd.res_status = lpht_pkg::ST_EXISTED;
                        cmd.res_vsel   = lpht_pkg::VS_READ;
                    end
                end else if (stat.free) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_FIN;
                    if (stat.is_lookup) begin
                        cmd.res_status = lpht_pkg::ST_MISS;
                    end else if (stat.full) begin
                        cmd.res_status    = lpht_pkg::ST_FULL;
                        cmd.res_slot_zero = 1'b1;
                    end else begin
                        cmd.wr         = 1'b1;
                        cmd.cnt_inc    = 1'b1;
                        cmd.res_status = lpht_pkg::ST_INSERTED;
                    end
                end else if (stat.exhausted) begin
                    cmd.res_load      = 1'b1;
                    cmd.res_slot_zero = 1'b1;
                    cmd.res_status    = stat.is_lookup ? lpht_pkg::ST_MISS : lpht_pkg::ST_FULL;
                    state_next        = S_FIN;
                end else begin
                    cmd.adv    = 1'b1;
                    state_next = S_READ;
                end
            end
            S_FIN: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/lpht_datapath.sv
// Config registers, key divider, slot memory, probe index and output register.
module lpht_datapath #(
    parameter int SLOTS      = lpht_pkg::DEF_SLOTS,
    parameter int KEY_BITS   = lpht_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = lpht_pkg::DEF_VALUE_BITS,
    parameter int IDXW       = $clog2(SLOTS),
    parameter int CNTW       = $clog2(SLOTS + 1),
    parameter int CFG_W      = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [lpht_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_W-1:0]                 cfg_data,
    input  logic [lpht_pkg::OP_BITS-1:0]     in_op,
    input  logic [KEY_BITS-1:0]              in_key,
    input  logic [VALUE_BITS-1:0]            in_value,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [lpht_pkg::STATUS_BITS-1:0] out_status,
    output logic [VALUE_BITS-1:0]            out_value,
    output logic [IDXW-1:0]                  out_slot,
    output logic [CNTW-1:0]                  out_count,
    input  lpht_pkg::cmd_t                   cmd,
    output lpht_pkg::stat_t                  stat
);

    localparam int EW  = 1 + KEY_BITS + VALUE_BITS;
    localparam int BCW = $clog2(KEY_BITS + 1);
    localparam int MW  = CNTW + 4;

    // slot entry: {valid, key, value}
    logic [EW-1:0] mem [SLOTS];
    logic [EW-1:0] rd_q;

    logic [CNTW-1:0]       n_reg, count_reg, clr_reg, rem_reg, steps_reg;
    logic [KEY_BITS-1:0]   ekey_reg, key_reg, sh_reg;
    logic [VALUE_BITS-1:0] eval_reg, val_reg;
    logic [lpht_pkg::OP_BITS-1:0] op_reg;
    logic [BCW-1:0]        bcnt_reg;
    logic [IDXW-1:0]       idx_reg;

    lpht_pkg::status_t     res_status_reg;
    logic [VALUE_BITS-1:0] res_value_reg;
    logic [IDXW-1:0]       res_slot_reg;
    logic                  m_valid_reg;

    logic [CNTW:0]         rem_sh;
    logic [CNTW-1:0]       rem_next;
    logic [CNTW-1:0]       cfg_slots;
    logic [IDXW-1:0]       idx_inc;
    logic [MW-1:0]         load_lhs, load_rhs;
    logic                  rd_valid;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_value;
    logic [IDXW-1:0]       wr_addr;
    logic [EW-1:0]         wr_data;

    assign rd_valid = rd_q[EW-1];
    assign rd_key   = rd_q[VALUE_BITS +: KEY_BITS];
    assign rd_value = rd_q[VALUE_BITS-1:0];

    // one restoring step of key mod n
    always_comb begin
        rem_sh   = {rem_reg, sh_reg[KEY_BITS-1]};
        rem_next = (rem_sh >= {1'b0, n_reg}) ? CNTW'(rem_sh - {1'b0, n_reg})
                                              : rem_sh[CNTW-1:0];
    end

    always_comb begin
        cfg_slots = cfg_data[CNTW-1:0];
        if (cfg_slots < CNTW'(2)) begin
            cfg_slots = CNTW'(2);
        end else if (cfg_slots > CNTW'(SLOTS)) begin
            cfg_slots = CNTW'(SLOTS);
        end
    end

    assign idx_inc = ({1'b0, idx_reg} + 1'b1 == (IDXW+1)'(n_reg)) ? '0 : idx_reg + 1'b1;

    // refused when count >= floor(n*8/10), i.e. 10*(count+1) > 8*n
    assign load_lhs = (MW'(count_reg) + MW'(1)) * MW'(lpht_pkg::LOAD_DEN);
    assign load_rhs = MW'(n_reg) * MW'(lpht_pkg::LOAD_NUM);

    always_comb begin
        stat            = '0;
        stat.clr_done   = (clr_reg == CNTW'(SLOTS));
        stat.div_done   = (bcnt_reg == '0);
        stat.is_lookup  = (op_reg != lpht_pkg::OP_INSERT) && (op_reg != lpht_pkg::OP_REPLACE);
        stat.is_replace = (op_reg == lpht_pkg::OP_REPLACE);
        stat.ek_refuse  = !stat.is_lookup && (key_reg == ekey_reg);
        stat.hit        = rd_valid && (rd_key == key_reg);
        stat.free       = !rd_valid;
        stat.exhausted  = (steps_reg == n_reg - 1'b1);
        stat.full       = (load_lhs > load_rhs);
        stat.out_free   = !m_valid_reg || m_tready;
    end

    always_comb begin
        if (cmd.clr_step) begin
            wr_addr = clr_reg[IDXW-1:0];
            wr_data = '0;
        end else begin
            wr_addr = idx_reg;
            wr_data = {1'b1, key_reg, val_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_step || cmd.wr) begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg       <= CNTW'(SLOTS);
            ekey_reg    <= '0;
            eval_reg    <= '0;
            count_reg   <= '0;
            clr_reg     <= '0;
            bcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    lpht_pkg::REG_SLOTS: begin
                        if (count_reg == '0) begin
                            n_reg <= cfg_slots;
                        end
                    end
                    lpht_pkg::REG_EMPTY_KEY:   ekey_reg <= cfg_data[KEY_BITS-1:0];
                    lpht_pkg::REG_EMPTY_VALUE: eval_reg <= cfg_data[VALUE_BITS-1:0];
                    default: ;
                endcase
            end
            if (cmd.clr_step) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.load) begin
                bcnt_reg <= BCW'(KEY_BITS);
            end else if (cmd.div_step) begin
                bcnt_reg <= bcnt_reg - 1'b1;
            end
            if (cmd.cnt_inc) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= in_op;
            key_reg <= in_key;
            val_reg <= in_value;
            sh_reg  <= in_key;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            sh_reg  <= sh_reg << 1;
            rem_reg <= rem_next;
        end
        if (cmd.probe_start) begin
            idx_reg   <= rem_reg[IDXW-1:0];
            steps_reg <= '0;
        end else if (cmd.adv) begin
            idx_reg   <= idx_inc;
            steps_reg <= steps_reg + 1'b1;
        end
        if (cmd.res_load) begin
            res_status_reg <= cmd.res_status;
            res_slot_reg   <= cmd.res_slot_zero ? '0 : idx_reg;
            case (cmd.res_vsel)
                lpht_pkg::VS_READ: res_value_reg <= rd_value;
                lpht_pkg::VS_NEW:  res_value_reg <= val_reg;
                default:           res_value_reg <= eval_reg;
            endcase
        end
        if (cmd.out_load) begin
            out_status <= res_status_reg;
            out_value  <= res_value_reg;
            out_slot   <= res_slot_reg;
            out_count  <= count_reg;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

FILE: hdl/linear_probe_hash_table.sv
// Top level: open addressing hash table with linear probing.
//
//  channel  | direction | contents
//  s_       | in        | tdata: op, key, new_value
//  m_       | out       | tdata: status, value_out, slot_index, entry_count
//  cfg_     | in        | write enable, register index, data
//
// Per item: accept, divide (key mod slots, one bit a cycle, then probe start), a
// memory read and a check per probed slot, result hand-off. An empty-key refusal
// skips the divide and probe. After reset a clearing pass runs over all SLOTS
// entries of the slot memory; s_tready stays low until it ends. Config writes
// are taken at any time, but a slot count write is ignored while the table
// holds entries. One item is in work at a time; a waiting result in the output
// register lets the next beat be accepted and run up to its hand-off.
module linear_probe_hash_table #(
    parameter int SLOTS      = lpht_pkg::DEF_SLOTS,
    parameter int KEY_BITS   = lpht_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = lpht_pkg::DEF_VALUE_BITS
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // op, key, new_value (low bit up), zero padded
    input  logic [((lpht_pkg::OP_BITS + KEY_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // status, value_out, slot_index, entry_count (low bit up), zero padded
    output logic [((lpht_pkg::STATUS_BITS + VALUE_BITS + $clog2(SLOTS)
                    + $clog2(SLOTS + 1) + 7) / 8) * 8 - 1:0] m_tdata,
    input  logic cfg_we,
    input  logic [lpht_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [((KEY_BITS > VALUE_BITS) ? KEY_BITS : VALUE_BITS) - 1:0] cfg_data
);

    localparam int IDXW  = $clog2(SLOTS);
    localparam int CNTW  = $clog2(SLOTS + 1);
    localparam int CFG_W = (KEY_BITS > VALUE_BITS) ? KEY_BITS : VALUE_BITS;
    localparam int SB    = lpht_pkg::STATUS_BITS;
    localparam int OB    = lpht_pkg::OP_BITS;
    localparam int MDW   = SB + VALUE_BITS + IDXW + CNTW;

    lpht_pkg::cmd_t  cmd;
    lpht_pkg::stat_t stat;

    logic [SB-1:0]         out_status;
    logic [VALUE_BITS-1:0] out_value;
    logic [IDXW-1:0]       out_slot;
    logic [CNTW-1:0]       out_count;

    lpht_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lpht_datapath #(
        .SLOTS      (SLOTS),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .IDXW       (IDXW),
        .CNTW       (CNTW),
        .CFG_W      (CFG_W)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_op      (s_tdata[OB-1:0]),
        .in_key     (s_tdata[OB +: KEY_BITS]),
        .in_value   (s_tdata[OB + KEY_BITS +: VALUE_BITS]),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_status (out_status),
        .out_value  (out_value),
        .out_slot   (out_slot),
        .out_count  (out_count),
        .cmd        (cmd),
        .stat       (stat)
    );

    assign m_tdata = $bits(m_tdata)'({out_count, out_slot, out_value, out_status});

    // a taken beat always moves the sequencer out of idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice in a row");

    // status code is always a defined result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[SB-1:0] <= SB'(lpht_pkg::ST_EMPTY_KEY)))
        else $error("undefined status code");

    // stored entries never pass the load limit of a full-size (SLOTS) table
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[MDW-1 -: CNTW] * lpht_pkg::LOAD_DEN
                      <= SLOTS * lpht_pkg::LOAD_NUM))
        else $error("entry count above load limit");

    // a result never leaves with no item in work
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !s_tready || $past(cmd.out_load))
        else $error("result without item");

endmodule

FILE: tb/sv/lpht_checker.sv
// Scoreboard for the hash table: tracks table contents and checks each result beat.
module lpht_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          outstanding,
    output int          n_results,
    output int          n_hits,
    output int          n_full
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        lpht_pkg::status_t status;
        logic [31:0]       value;
        logic [9:0]        slot;
        logic [10:0]       count;
    } table_result_t;

    bit          occupied [lpht_pkg::DEF_SLOTS];
    logic [31:0] stored_key [lpht_pkg::DEF_SLOTS];
    logic [31:0] stored_val [lpht_pkg::DEF_SLOTS];
    int          entries;
    int          slot_limit;
    logic [31:0] empty_key;
    logic [31:0] empty_val;

    table_result_t expected_q[$];

    // Returns 1 when the walk stops at the key or at a free slot.
    function automatic bit walk_probe(input logic [31:0] k, output int slot, output bit found);
        int idx;
        idx = int'(k % slot_limit);
        found = 0;
        slot = 0;
        for (int i = 0; i < slot_limit; i++) begin
            if (!occupied[idx]) begin
                slot = idx;
                return 1;
            end
            if (stored_key[idx] == k) begin
                slot = idx;
                found = 1;
                return 1;
            end
            idx = (idx + 1 >= slot_limit) ? 0 : idx + 1;
        end
        return 0;
    endfunction

    function automatic table_result_t apply_op(input logic [1:0] op, input logic [31:0] k,
                                               input logic [31:0] v);
        table_result_t r;
        int slot;
        bit found;
        bit stopped;
        r.value = empty_val;
        r.slot = '0;
        if (op == lpht_pkg::OP_INSERT || op == lpht_pkg::OP_REPLACE) begin
            if (k == empty_key) begin
                r.status = lpht_pkg::ST_EMPTY_KEY;
            end else begin
                stopped = walk_probe(k, slot, found);
                if (stopped && found) begin
                    if (op == lpht_pkg::OP_REPLACE) stored_val[slot] = v;
                    r.value = stored_val[slot];
                    r.slot = slot[9:0];
                    r.status = lpht_pkg::ST_EXISTED;
                end else if (!stopped || entries >=
                             slot_limit * lpht_pkg::LOAD_NUM / lpht_pkg::LOAD_DEN) begin
                    r.status = lpht_pkg::ST_FULL;
                end else begin
                    occupied[slot] = 1;
                    stored_key[slot] = k;
                    stored_val[slot] = v;
                    entries++;
                    r.slot = slot[9:0];
                    r.status = lpht_pkg::ST_INSERTED;
                end
            end
        end else begin
            // op code three falls through here as a lookup
            stopped = walk_probe(k, slot, found);
            if (stopped && found) begin
                r.value = stored_val[slot];
                r.slot = slot[9:0];
                r.status = lpht_pkg::ST_HIT;
            end else begin
                r.slot = stopped ? slot[9:0] : 10'd0;
                r.status = lpht_pkg::ST_MISS;
            end
        end
        r.count = entries[10:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        table_result_t want;
        table_result_t got;
        int sl;
        if (!aresetn) begin
            foreach (occupied[i]) occupied[i] = 0;
            entries = 0;
            slot_limit = lpht_pkg::DEF_SLOTS;
            empty_key = '0;
            empty_val = '0;
            expected_q.delete();
            fail_count = 0;
            n_results = 0;
            n_hits = 0;
            n_full = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    lpht_pkg::REG_SLOTS: begin
                        if (entries == 0) begin
                            sl = int'(cfg_data[10:0]);
                            slot_limit = (sl < 2) ? 2 :
                                         (sl > lpht_pkg::DEF_SLOTS) ? lpht_pkg::DEF_SLOTS : sl;
                        end
                    end
                    lpht_pkg::REG_EMPTY_KEY:   empty_key = cfg_data;
                    lpht_pkg::REG_EMPTY_VALUE: empty_val = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(apply_op(s_tdata[1:0], s_tdata[33:2], s_tdata[65:34]));
            if (m_tvalid && m_tready) begin
                got.status = lpht_pkg::status_t'(m_tdata[2:0]);
                got.value = m_tdata[34:3];
                got.slot = m_tdata[44:35];
                got.count = m_tdata[55:45];
                n_results++;
                if (got.status == lpht_pkg::ST_HIT) n_hits++;
                if (got.status == lpht_pkg::ST_FULL) n_full++;
                if (expected_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected: %h", $time, m_tdata);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.status != want.status) begin
                        $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                        fail_count++;
                    end
                    if (got.value != want.value) begin
                        $display("%0t: value exp %h got %h", $time, want.value, got.value);
                        fail_count++;
                    end
                    if (got.slot != want.slot) begin
                        $display("%0t: slot exp %0d got %0d", $time, want.slot, got.slot);
                        fail_count++;
                    end
                    if (got.count != want.count) begin
                        $display("%0t: count exp %0d got %0d", $time, want.count, got.count);
                        fail_count++;
                    end
                end
            end
        end
        outstanding = expected_q.size();
    end
endmodule

FILE: tb/sv/tb.sv
// Testbench top: drives requests and register writes, reports the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_LOOKUP  = 2'd0;
    localparam logic [1:0] OP_LOOKUP3 = 2'd3;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [55:0] m_tdata;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = lpht_pkg::REG_SLOTS;
    logic [31:0] cfg_data = '0;

    int fail_count, outstanding, n_results, n_hits, n_full;
    bit calm = 0;
    int tbl_size;
    logic [31:0] cur_ek;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    linear_probe_hash_table uut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
        .cfg_we, .cfg_index, .cfg_data
    );

    lpht_checker chk (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
        .cfg_we, .cfg_index, .cfg_data, .fail_count, .outstanding, .n_results, .n_hits,
        .n_full
    );

    always @(negedge aclk) m_tready <= calm || ($urandom_range(0, 99) >= 10);

    task automatic send_req(input logic [1:0] op, input logic [31:0] k, input logic [31:0] v);
        @(negedge aclk);
        while (!calm && $urandom_range(0, 99) < 10) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {6'b0, v, k, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] d);
        @(negedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= d;
        @(negedge aclk);
        cfg_we <= 0;
    endtask

    // drop valid, then let every pending result drain
    task automatic drain;
        @(negedge aclk);
        s_tvalid <= 0;
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_key;
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 3 * tbl_size);
        if (r < 82) return $urandom;
        if (r < 87) return 32'hFFFF_FFFF;
        if (r < 93) return cur_ek;
        return 32'h8000_0000 + $urandom_range(0, 3 * tbl_size);
    endfunction

    function automatic logic [1:0] pick_op;
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return OP_LOOKUP;
        if (r < 60) return lpht_pkg::OP_INSERT;
        if (r < 90) return lpht_pkg::OP_REPLACE;
        return OP_LOOKUP3;
    endfunction

    initial begin
        #20_000_000;
        $display("linear_probe_hash_table regression: fail");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // slot count clamped low, zero keys refused
        write_reg(lpht_pkg::REG_SLOTS, 32'd0);
        send_req(OP_LOOKUP, 32'd0, 32'd0);
        send_req(OP_LOOKUP, 32'hFFFF_FFFF, 32'd0);
        send_req(lpht_pkg::OP_INSERT, 32'd0, 32'hFFFF_FFFF);
        send_req(lpht_pkg::OP_REPLACE, 32'd0, 32'h1234_5678);
        send_req(OP_LOOKUP3, 32'd1, 32'd0);
        drain();
        // clamped high, all-ones empty key and value
        write_reg(lpht_pkg::REG_SLOTS, 32'h7FF);
        write_reg(lpht_pkg::REG_EMPTY_KEY, 32'hFFFF_FFFF);
        write_reg(lpht_pkg::REG_EMPTY_VALUE, 32'hFFFF_FFFF);
        send_req(OP_LOOKUP, 32'd1023, 32'd0);
        send_req(lpht_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'd7);
        send_req(OP_LOOKUP, 32'hFFFF_FFFF, 32'd0);
        drain();

        tbl_size = $urandom_range(3, 80);
        cur_ek = 32'd5;
        write_reg(lpht_pkg::REG_SLOTS, tbl_size);
        write_reg(lpht_pkg::REG_EMPTY_KEY, cur_ek);
        write_reg(lpht_pkg::REG_EMPTY_VALUE, 32'hA5A5_5A5A);
        send_req(lpht_pkg::OP_INSERT, 32'd0, 32'h0000_0001);
        send_req(lpht_pkg::OP_INSERT, 32'd0, 32'h0000_0002);
        send_req(lpht_pkg::OP_REPLACE, 32'd0, 32'hFFFF_FFFF);
        send_req(OP_LOOKUP, 32'd0, 32'd0);
        send_req(lpht_pkg::OP_INSERT, tbl_size, 32'd3);
        send_req(lpht_pkg::OP_REPLACE, tbl_size - 1, 32'd4);
        send_req(lpht_pkg::OP_INSERT, 2 * tbl_size - 1, 32'd5);
        send_req(OP_LOOKUP, 3 * tbl_size, 32'd0);
        send_req(lpht_pkg::OP_INSERT, cur_ek, 32'd6);
        send_req(OP_LOOKUP, cur_ek, 32'd0);
        send_req(OP_LOOKUP3, tbl_size, 32'd0);
        drain();
        // table in use: this write must be ignored
        write_reg(lpht_pkg::REG_SLOTS, 32'd2);

        for (int ph = 0; ph < 4; ph++) begin
            for (int n = 0; n < 310; n++) begin
                calm = (ph == 2 && n >= 60 && n < 200);
                send_req(pick_op(), pick_key(), $urandom);
            end
            calm = 0;
            drain();
            cur_ek = (ph == 1) ? 32'hFFFF_FFFF : (ph == 2) ? 32'd0 : $urandom_range(0, tbl_size);
            write_reg(lpht_pkg::REG_EMPTY_KEY, cur_ek);
            write_reg(lpht_pkg::REG_EMPTY_VALUE, $urandom);
        end

        repeat (50) @(negedge aclk);
        $display("table of %0d slots: %0d results checked, %0d hits, %0d refused as full",
                 tbl_size, n_results, n_hits, n_full);
        if (fail_count == 0 && outstanding == 0) begin
            $display("linear_probe_hash_table regression: pass");
        end else begin
            $display("linear_probe_hash_table regression: fail");
        end
        $finish;
    end
endmodule

FILE: filelist.f
hdl/lpht_pkg.sv
hdl/lpht_ctrl.sv
hdl/lpht_datapath.sv
hdl/linear_probe_hash_table.sv
tb/sv/lpht_checker.sv
tb/sv/tb.sv
